FILE: hw/rtl/bpa_pkg.sv
// Bitmap page allocator package: operation, status and register codes.
// Used by the engine and the top level; no dependencies.
`default_nettype none
package bpa_pkg;

    localparam int OP_W     = 2;
    localparam int PAGE_W   = 14;
    localparam int COUNT_W  = 15;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_INIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RUN   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd3;

    localparam logic CFG_TOTAL    = 1'b0;
    localparam logic CFG_RESERVED = 1'b1;

    localparam logic [1:0] PH_INIT = 2'd0;
    localparam logic [1:0] PH_SCAN = 2'd1;
    localparam logic [1:0] PH_MARK = 2'd2;
    localparam logic [1:0] PH_FREE = 2'd3;

endpackage
`default_nettype wire

FILE: hw/rtl/bitmap_page_allocator_top.sv
// Bitmap first-fit page allocator top: configuration registers, map storage, sequencer.
// Depends on bpa_pkg, bpa_map and bpa_engine.
//
//   channel   direction  ports
//   s_        in         s_valid/s_ready, s_operation, s_page_number, s_page_count
//   m_        out        m_valid/m_ready, m_status, m_start_page, m_free_count
//   cfg_      in         cfg_valid/cfg_ready, cfg_index, cfg_data
//
// After reset the map is filled with used marks, one word a cycle, with s_ready low;
// configuration writes are taken throughout. Queries and rejected requests skip the map.
// Init, allocate and free walk the map through its write port and registered read port:
// each word is read and loaded, then handled whole at once, or page by page inside a
// partly used or boundary word, and is written back.
// One transaction is in flight at a time; a pending result stalls only the next finish.
`default_nettype none
module bitmap_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES     = 16384,
    parameter int MAP_WORD_BITS = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [OP_W-1:0]     s_operation,
    input  wire logic [PAGE_W-1:0]   s_page_number,
    input  wire logic [COUNT_W-1:0]  s_page_count,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [PAGE_W-1:0]        m_start_page,
    output logic [COUNT_W-1:0]       m_free_count,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [COUNT_W-1:0]  cfg_data
);

    localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(MAP_WORD_BITS);
    localparam int PW        = $clog2(MAP_WORDS * MAP_WORD_BITS) + 1;
    localparam int CW        = (PW > 16) ? PW : 16;
    localparam logic [CW-1:0] MAXP = CW'(MAX_PAGES);

    logic [COUNT_W-1:0]       total_reg;
    logic [COUNT_W-1:0]       reserved_reg;
    logic [CW-1:0]            limit;
    logic                     mem_we;
    logic [WW-1:0]            mem_waddr;
    logic [MAP_WORD_BITS-1:0] mem_wdata;
    logic                     mem_re;
    logic [WW-1:0]            mem_raddr;
    logic [MAP_WORD_BITS-1:0] mem_rdata;

    assign cfg_ready = 1'b1;
    assign limit     = (CW'(total_reg) > MAXP) ? MAXP : CW'(total_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= COUNT_W'(16384);
            reserved_reg <= COUNT_W'(256);
        end else if (cfg_valid) begin
            if (cfg_index == CFG_TOTAL) begin
                total_reg <= cfg_data;
            end else begin
                reserved_reg <= cfg_data;
            end
        end
    end

    bpa_map #(
        .WORDS (MAP_WORDS),
        .WIDTH (MAP_WORD_BITS),
        .AW    (WW)
    ) u_map (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bpa_engine #(
        .MAP_WORDS     (MAP_WORDS),
        .MAP_WORD_BITS (MAP_WORD_BITS),
        .WW            (WW),
        .BW            (BW),
        .CW            (CW)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_page_number (s_page_number),
        .s_page_count  (s_page_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_start_page  (m_start_page),
        .m_free_count  (m_free_count),
        .limit         (limit),
        .reserved      (reserved_reg),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    a_not_init_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_NOT_INIT |-> m_free_count == '0)
        else $error("not-initialized result carries a free count");

    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_start_page == '0)
        else $error("failed transaction carries a start page");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while one is in flight");

endmodule
`default_nettype wire

FILE: hw/rtl/bpa_map.sv
// Used-bit map storage: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module bpa_map #(
    parameter int WORDS = 512,
    parameter int WIDTH = 32,
    parameter int AW    = 9
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/bpa_engine.sv
// Allocator sequencer: walks the used-bit map one word or one page a cycle, stopping to read each word.
// Depends on bpa_pkg; drives the bpa_map ports.
`default_nettype none
module bpa_engine
    import bpa_pkg::*;
#(
    parameter int MAP_WORDS     = 512,
    parameter int MAP_WORD_BITS = 32,
    parameter int WW            = 9,
    parameter int BW            = 5,
    parameter int CW            = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [OP_W-1:0]          s_operation,
    input  wire logic [PAGE_W-1:0]        s_page_number,
    input  wire logic [COUNT_W-1:0]       s_page_count,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [STATUS_W-1:0]           m_status,
    output logic [PAGE_W-1:0]             m_start_page,
    output logic [COUNT_W-1:0]            m_free_count,
    input  wire logic [CW-1:0]            limit,
    input  wire logic [COUNT_W-1:0]       reserved,
    output logic                          mem_we,
    output logic [WW-1:0]                 mem_waddr,
    output logic [MAP_WORD_BITS-1:0]      mem_wdata,
    output logic                          mem_re,
    output logic [WW-1:0]                 mem_raddr,
    input  wire logic [MAP_WORD_BITS-1:0] mem_rdata
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_RUN   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [CW-1:0] WBITS = CW'(MAP_WORD_BITS);
    localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);
    localparam logic [BW-1:0] LAST_BIT = BW'(MAP_WORD_BITS - 1);

    function automatic logic [BW:0] ones_in(input logic [MAP_WORD_BITS-1:0] w);
        logic [BW:0] n;
        n = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++) begin
            n = n + {{BW{1'b0}}, w[i]};
        end
        return n;
    endfunction

    logic [2:0]               state_reg, state_next;
    logic [1:0]               phase_reg, phase_next;
    logic [WW-1:0]            clr_reg, clr_next;
    logic [CW-1:0]            p_reg, p_next;
    logic [CW-1:0]            end_reg, end_next;
    logic [WW-1:0]            waddr_reg, waddr_next;
    logic [MAP_WORD_BITS-1:0] wbuf_reg, wbuf_next;
    logic [15:0]              run_reg, run_next;
    logic [CW-1:0]            rstart_reg, rstart_next;
    logic [COUNT_W-1:0]       rem_reg, rem_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic [COUNT_W-1:0]       free_reg, free_next;
    logic                     ready_reg, ready_next;
    logic [STATUS_W-1:0]      rstat_reg, rstat_next;
    logic [PAGE_W-1:0]        rpage_reg, rpage_next;
    logic                     m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]      m_status_reg, m_status_next;
    logic [PAGE_W-1:0]        m_page_reg, m_page_next;
    logic [COUNT_W-1:0]       m_free_reg, m_free_next;

    logic [BW-1:0]            bidx;
    logic                     bit_used;
    logic                     at_start;
    logic                     word_fit;
    logic                     at_end;
    logic                     leave;
    logic [MAP_WORD_BITS-1:0] wnew;
    logic [CW-1:0]            res_ext;
    logic [CW-1:0]            free_end;
    logic [15:0]              run_inc;

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_start_page = m_page_reg;
    assign m_free_count = m_free_reg;

    assign bidx     = p_reg[BW-1:0];
    assign bit_used = wbuf_reg[bidx];
    assign at_start = (bidx == '0);
    assign word_fit = (p_reg + WBITS) <= end_reg;
    assign at_end   = (phase_reg == PH_MARK) ? (rem_reg == '0) : (p_reg >= end_reg);
    assign res_ext  = CW'(reserved);
    assign run_inc  = run_reg + 16'd1;
    assign free_end = ((CW'(s_page_number) + CW'(s_page_count)) > limit) ? limit
                    : (CW'(s_page_number) + CW'(s_page_count));

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        clr_next     = clr_reg;
        p_next       = p_reg;
        end_next     = end_reg;
        waddr_next   = waddr_reg;
        wbuf_next    = wbuf_reg;
        run_next     = run_reg;
        rstart_next  = rstart_reg;
        rem_next     = rem_reg;
        count_next   = count_reg;
        free_next    = free_reg;
        ready_next   = ready_reg;
        rstat_next   = rstat_reg;
        rpage_next   = rpage_reg;
        m_valid_next = m_valid_reg;
        m_status_next = m_status_reg;
        m_page_next  = m_page_reg;
        m_free_next  = m_free_reg;
        mem_we       = 1'b0;
        mem_waddr    = waddr_reg;
        mem_wdata    = wbuf_reg;
        mem_re       = 1'b0;
        mem_raddr    = p_reg[BW +: WW];
        wnew         = wbuf_reg;
        leave        = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_WORD) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    rstat_next = ST_OK;
                    rpage_next = '0;
                    count_next = s_page_count;
                    run_next   = '0;
                    state_next = S_DONE;
                    if (s_operation == OP_INIT) begin
                        if (ready_reg) begin
                            rstat_next = ST_IGNORED;
                        end else begin
                            free_next  = '0;
                            p_next     = '0;
                            end_next   = limit;
                            phase_next = PH_INIT;
                            state_next = S_READ;
                        end
                    end else if (!ready_reg) begin
                        rstat_next = ST_NOT_INIT;
                    end else if (s_operation == OP_ALLOC || s_operation == OP_FREE) begin
                        if (s_page_count == '0) begin
                            rstat_next = ST_IGNORED;
                        end else if (s_operation == OP_ALLOC) begin
                            p_next     = '0;
                            end_next   = limit;
                            phase_next = PH_SCAN;
                            state_next = S_READ;
                        end else begin
                            p_next     = CW'(s_page_number);
                            end_next   = free_end;
                            phase_next = PH_FREE;
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                mem_re     = 1'b1;
                waddr_next = p_reg[BW +: WW];
                state_next = S_LOAD;
            end
            S_LOAD: begin
                wbuf_next  = mem_rdata;
                state_next = S_RUN;
            end
            S_RUN: begin
                if (at_end) begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                    case (phase_reg)
                        PH_INIT: ready_next = 1'b1;
                        PH_SCAN: rstat_next = ST_NO_RUN;
                        PH_MARK: begin
                            free_next  = free_reg - count_reg;
                            rpage_next = rstart_reg[PAGE_W-1:0];
                        end
                        default: ;
                    endcase
                end else begin
                    case (phase_reg)
                        PH_INIT: begin
                            if (at_start && word_fit &&
                                (p_reg >= res_ext || (p_reg + WBITS) <= res_ext)) begin
                                wnew   = (p_reg >= res_ext) ? '0 : '1;
                                free_next = (p_reg >= res_ext)
                                          ? free_reg + COUNT_W'(MAP_WORD_BITS) : free_reg;
                                p_next = p_reg + WBITS;
                                leave  = 1'b1;
                            end else begin
                                wnew[bidx] = !(p_reg >= res_ext);
                                free_next  = free_reg + COUNT_W'(p_reg >= res_ext);
                                p_next     = p_reg + 1'b1;
                                leave      = (bidx == LAST_BIT);
                            end
                        end
                        PH_SCAN: begin
                            if (at_start && word_fit && wbuf_reg == '0 &&
                                (run_reg + 16'(MAP_WORD_BITS)) < 16'(count_reg)) begin
                                if (run_reg == '0) begin
                                    rstart_next = p_reg;
                                end
                                run_next = run_reg + 16'(MAP_WORD_BITS);
                                p_next   = p_reg + WBITS;
                                leave    = 1'b1;
                            end else if (at_start && word_fit && wbuf_reg == '1) begin
                                run_next = '0;
                                p_next   = p_reg + WBITS;
                                leave    = 1'b1;
                            end else if (!bit_used) begin
                                if (run_reg == '0) begin
                                    rstart_next = p_reg;
                                end
                                run_next = run_inc;
                                if (run_inc == 16'(count_reg)) begin
                                    p_next     = (run_reg == '0) ? p_reg : rstart_reg;
                                    rem_next   = count_reg;
                                    phase_next = PH_MARK;
                                    leave      = 1'b1;
                                end else begin
                                    p_next = p_reg + 1'b1;
                                    leave  = (bidx == LAST_BIT);
                                end
                            end else begin
                                run_next = '0;
                                p_next   = p_reg + 1'b1;
                                leave    = (bidx == LAST_BIT);
                            end
                        end
                        PH_MARK: begin
                            if (at_start && rem_reg >= COUNT_W'(MAP_WORD_BITS)) begin
                                wnew     = '1;
                                rem_next = rem_reg - COUNT_W'(MAP_WORD_BITS);
                                p_next   = p_reg + WBITS;
                                leave    = 1'b1;
                            end else begin
                                wnew[bidx] = 1'b1;
                                rem_next   = rem_reg - 1'b1;
                                p_next     = p_reg + 1'b1;
                                leave      = (bidx == LAST_BIT);
                            end
                        end
                        default: begin
                            if (at_start && word_fit) begin
                                wnew      = '0;
                                free_next = free_reg + COUNT_W'(ones_in(wbuf_reg));
                                p_next    = p_reg + WBITS;
                                leave     = 1'b1;
                            end else begin
                                wnew[bidx] = 1'b0;
                                free_next  = free_reg + COUNT_W'(bit_used);
                                p_next     = p_reg + 1'b1;
                                leave      = (bidx == LAST_BIT);
                            end
                        end
                    endcase
                    if (leave) begin
                        mem_we     = 1'b1;
                        mem_wdata  = wnew;
                        state_next = S_READ;
                    end else begin
                        wbuf_next = wnew;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = rstat_reg;
                    m_page_next   = rpage_reg;
                    m_free_next   = ready_reg ? free_reg : '0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            free_reg    <= '0;
            ready_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            phase_reg   <= PH_INIT;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            free_reg    <= free_next;
            ready_reg   <= ready_next;
            m_valid_reg <= m_valid_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg        <= p_next;
        end_reg      <= end_next;
        waddr_reg    <= waddr_next;
        wbuf_reg     <= wbuf_next;
        run_reg      <= run_next;
        rstart_reg   <= rstart_next;
        rem_reg      <= rem_next;
        count_reg    <= count_next;
        rstat_reg    <= rstat_next;
        rpage_reg    <= rpage_next;
        m_status_reg <= m_status_next;
        m_page_reg   <= m_page_next;
        m_free_reg   <= m_free_next;
    end

endmodule
`default_nettype wire

FILE: dv/bitmap_page_allocator_top_test.sv
// Self-checking testbench for the bitmap first-fit page allocator.
// Holds its own page map model, drives random and directed transactions with
// random idling on both sides, and checks every result in order. Needs bpa_pkg and the top.
`timescale 1ns / 1ps
module bitmap_page_allocator_top_test;
    import bpa_pkg::*;

    localparam int PAGE_SPAN  = 16384;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   start_page;
        logic [COUNT_W-1:0]  free_count;
    } page_result_t;

    typedef struct {
        int base;
        int len;
    } page_run_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation = OP_QUERY;
    logic [PAGE_W-1:0]   s_page_number = '0;
    logic [COUNT_W-1:0]  s_page_count = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [PAGE_W-1:0]   m_start_page;
    logic [COUNT_W-1:0]  m_free_count;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = CFG_TOTAL;
    logic [COUNT_W-1:0]  cfg_data = '0;

    bit           page_taken[PAGE_SPAN];
    int           free_tally;
    bit           map_ready;
    int           total_reg;
    int           reserved_reg;
    page_result_t pending_results[$];
    page_run_t    live_runs[$];

    int errors;
    int sent_count;
    int checked_count;
    int alloc_hits;
    int alloc_misses;
    int idle_cycles;
    int rx_gap;
    int rx_hold;
    bit tx_no_idle;
    bit rx_no_idle;

    bitmap_page_allocator_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_page_number (s_page_number),
        .s_page_count  (s_page_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_start_page  (m_start_page),
        .m_free_count  (m_free_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int page_limit();
        return (total_reg > PAGE_SPAN) ? PAGE_SPAN : total_reg;
    endfunction

    function automatic page_result_t predict_page_op(logic [OP_W-1:0] op, int first, int cnt);
        page_result_t res;
        int lim;
        int run;
        int run_base;
        int stop;
        bit found;
        page_run_t r;
        res = '0;
        lim = page_limit();
        if (op == OP_INIT) begin
            if (map_ready) begin
                res.status = ST_IGNORED;
            end else begin
                free_tally = 0;
                for (int i = 0; i < lim; i++) begin
                    page_taken[i] = (i < reserved_reg);
                    if (i >= reserved_reg) free_tally++;
                end
                map_ready = 1'b1;
            end
        end else if (!map_ready) begin
            res.status = ST_NOT_INIT;
        end else if (op == OP_ALLOC) begin
            if (cnt == 0) begin
                res.status = ST_IGNORED;
            end else begin
                run = 0;
                run_base = 0;
                found = 1'b0;
                for (int i = 0; i < lim && !found; i++) begin
                    if (!page_taken[i]) begin
                        if (run == 0) run_base = i;
                        run++;
                        if (run == cnt) found = 1'b1;
                    end else begin
                        run = 0;
                    end
                end
                if (found) begin
                    for (int i = run_base; i < run_base + cnt; i++) page_taken[i] = 1'b1;
                    free_tally -= cnt;
                    res.start_page = run_base;
                    r.base = run_base;
                    r.len = cnt;
                    live_runs.push_back(r);
                    alloc_hits++;
                end else begin
                    res.status = ST_NO_RUN;
                    alloc_misses++;
                end
            end
        end else if (op == OP_FREE) begin
            if (cnt == 0) begin
                res.status = ST_IGNORED;
            end else begin
                stop = (first + cnt > lim) ? lim : first + cnt;
                for (int i = first; i < stop; i++) begin
                    if (page_taken[i]) begin
                        page_taken[i] = 1'b0;
                        free_tally++;
                    end
                end
            end
        end
        res.free_count = map_ready ? free_tally : 0;
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
                 checked_count);
    endtask

    task automatic send_page_op(logic [OP_W-1:0] op, int first, int cnt);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 6);
        @(negedge aclk);
        repeat (gap) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_operation   = op;
        s_page_number = first[PAGE_W-1:0];
        s_page_count  = cnt[COUNT_W-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_page_op(op, first, cnt));
        sent_count++;
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, int value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value[COUNT_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_TOTAL) total_reg = value & 16'h7FFF;
        else reserved_reg = value & 16'h7FFF;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_random_op();
        int r;
        int lim;
        int k;
        page_run_t pr;
        lim = page_limit();
        r = $urandom_range(0, 99);
        if (r < 42) begin
            if ($urandom_range(0, 19) == 0) send_page_op(OP_ALLOC, $urandom_range(0, 16383),
                                                         $urandom_range(0, 16384));
            else send_page_op(OP_ALLOC, $urandom_range(0, 16383),
                              $urandom_range(1, (lim > 8) ? lim / 4 : 2));
        end else if (r < 82) begin
            if (live_runs.size() != 0 && $urandom_range(0, 4) != 0) begin
                k = $urandom_range(0, live_runs.size() - 1);
                pr = live_runs[k];
                live_runs.delete(k);
                if ($urandom_range(0, 3) == 0) send_page_op(OP_FREE, pr.base,
                                                            $urandom_range(1, pr.len + 3));
                else send_page_op(OP_FREE, pr.base, pr.len);
            end else if ($urandom_range(0, 3) == 0) begin
                send_page_op(OP_FREE, $urandom_range(0, 16383), $urandom_range(0, 16384));
            end else begin
                send_page_op(OP_FREE, $urandom_range(0, lim), $urandom_range(1, 16));
            end
        end else if (r < 92) begin
            send_page_op(OP_QUERY, $urandom_range(0, 16383), $urandom_range(0, 16384));
        end else if (r < 96) begin
            send_page_op(OP_INIT, $urandom_range(0, 16383), $urandom_range(0, 16384));
        end else begin
            send_page_op(r[0] ? OP_ALLOC : OP_FREE, $urandom_range(0, 16383), 0);
        end
    endtask

    task automatic test_before_init();
        write_reg(CFG_TOTAL, 1000);
        write_reg(CFG_RESERVED, 2000);
        send_page_op(OP_ALLOC, 0, 5);
        send_page_op(OP_FREE, 16383, 16384);
        send_page_op(OP_QUERY, 0, 0);
        send_page_op(OP_ALLOC, 0, 0);
        wait_drained();
    endtask

    task automatic test_init_once();
        send_page_op(OP_INIT, 0, 0);
        send_page_op(OP_INIT, 16383, 16384);
        send_page_op(OP_QUERY, 0, 0);
        wait_drained();
    endtask

    task automatic test_directed();
        send_page_op(OP_FREE, 0, 16384);
        send_page_op(OP_ALLOC, 0, 0);
        send_page_op(OP_FREE, 10, 0);
        send_page_op(OP_ALLOC, 0, 1);
        send_page_op(OP_ALLOC, 0, 1000);
        send_page_op(OP_ALLOC, 0, 16384);
        send_page_op(OP_FREE, 16383, 1);
        send_page_op(OP_FREE, 500, 20);
        send_page_op(OP_FREE, 0, 1);
        wait_drained();
        write_reg(CFG_TOTAL, 16384);
        write_reg(CFG_RESERVED, 0);
        send_page_op(OP_FREE, 0, 16384);
        send_page_op(OP_ALLOC, 0, 16384);
        send_page_op(OP_QUERY, 0, 0);
        send_page_op(OP_FREE, 0, 16384);
        wait_drained();
        write_reg(CFG_TOTAL, 32767);
        write_reg(CFG_RESERVED, 16384);
        send_page_op(OP_ALLOC, 0, 3);
        send_page_op(OP_FREE, 16383, 2);
        wait_drained();
        write_reg(CFG_TOTAL, 0);
        send_page_op(OP_ALLOC, 0, 1);
        send_page_op(OP_FREE, 0, 5);
        send_page_op(OP_QUERY, 0, 0);
        wait_drained();
    endtask

    task automatic test_random_mix();
        int totals[9] = '{64, 200, 33, 1, 256, 16384, 97, 128, 48};
        int counts[9] = '{250, 250, 200, 40, 250, 25, 250, 250, 250};
        for (int p = 0; p < 9; p++) begin
            write_reg(CFG_TOTAL, totals[p]);
            write_reg(CFG_RESERVED, $urandom_range(0, 16384));
            live_runs.delete();
            tx_no_idle = (p % 3 == 1);
            rx_no_idle = (p % 3 == 2);
            for (int n = 0; n < counts[p]; n++) send_random_op();
            wait_drained();
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        write_reg(CFG_TOTAL, 128);
        rx_hold = 400;
        for (int n = 0; n < 12; n++) send_random_op();
        wait_drained();
        for (int n = 0; n < 30; n++) send_random_op();
        wait_drained();
    endtask

    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready = 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready = 1'b0;
            end else begin
                m_ready = aresetn;
            end
        end
    end

    always @(posedge aclk) begin
        page_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", m_status, -1);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_start_page !== want.start_page)
                    report_mismatch("start_page", m_start_page, want.start_page);
                if (m_free_count !== want.free_count)
                    report_mismatch("free_count", m_free_count, want.free_count);
            end
            checked_count++;
            rx_gap = rx_no_idle ? 0 : $urandom_range(0, 6);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        total_reg = 16384;
        reserved_reg = 256;
        free_tally = 0;
        map_ready = 1'b0;
        for (int i = 0; i < PAGE_SPAN; i++) page_taken[i] = 1'b1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_before_init();
        test_init_once();
        test_directed();
        test_random_mix();
        test_backpressure();
        wait_drained();
        repeat (50) @(posedge aclk);
        $display("Sent %0d transactions, checked %0d results; %0d allocations placed, %0d refused.",
                 sent_count, checked_count, alloc_hits, alloc_misses);
        $display("Covered pre-init rejects, repeated init, live page limits 0..32767 and stalls.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
